FILE: hw/rtl/wpbl_pkg.sv
// Shared types and constants for the window product below limit counter.
// Holds the payload structs, the sequencer state type and the field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpbl_pkg;

  localparam int LIMIT_W = 20;
  localparam int COUNT_W = 20;
  localparam int VALUE_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int MAX_LEN_DEF    = 1024;
  localparam int VALUE_BITS_DEF = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_last;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] subarray_count;
    logic               overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_READ,
    S_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/window_product_below_limit_count.sv
// Top level of the window product below limit counter.
// Holds the ring memory, the product datapath, the serial divider and the sequencer.
// Depends on wpbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Word
// cfg       cfg_valid/cfg_ready   cfg_data: product limit, 20 bits
// in        in_valid/in_stall     in_word: value, is_last
// out       out_valid/out_stall   out_word: subarray_count, overflow
//
// An item that fits in the ring passes through S_MUL and S_CHECK, and each value
// divided out of the window adds a pass through S_READ and the bit-serial divider
// in S_DIV, back to S_CHECK. A last item then goes to S_DONE to load the result.
// Reset (rst, synchronous) clears the limit and all array state; the ring needs no clearing.
// The input stalls while an item is in work, and a last item waits while the
// output register still holds an untaken result.
module window_product_below_limit_count #(
  parameter int MAX_LEN    = wpbl_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = wpbl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [wpbl_pkg::LIMIT_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire wpbl_pkg::in_word_t         in_word,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output wpbl_pkg::out_word_t             out_word
);
  import wpbl_pkg::*;

  localparam int HEAD_W = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int SLOT_W = LEN_W + 1;
  localparam int PROD_W = LIMIT_W + VALUE_BITS;
  localparam int DCNT_W = $clog2(PROD_W);

  state_t state, state_next;

  logic [LIMIT_W-1:0]    limit;
  logic [PROD_W-1:0]     product;
  logic [HEAD_W-1:0]     head;
  logic [LEN_W-1:0]      length;
  logic [COUNT_W-1:0]    count;
  logic [LEN_W-1:0]      seen;
  logic                  ovf;
  logic                  last_flag;
  logic [VALUE_BITS-1:0] v_reg;
  logic [VALUE_BITS-1:0] divisor;
  logic [VALUE_BITS-1:0] rd_data;
  logic [PROD_W-1:0]     div_q;
  logic [VALUE_BITS-1:0] div_rem;
  logic [DCNT_W-1:0]     div_cnt;

  logic [VALUE_BITS-1:0] mem [MAX_LEN];

  logic [VALUE_W+VALUE_BITS-1:0] v_ext;
  logic [VALUE_BITS-1:0] v_in;
  logic                  accept;
  logic                  full;
  logic [SLOT_W-1:0]     slot_sum;
  logic [HEAD_W-1:0]     slot;
  logic [HEAD_W-1:0]     head_inc;
  logic                  shrink;
  logic [COUNT_W:0]      count_sum;
  logic [COUNT_W-1:0]    count_sat;
  logic [VALUE_BITS:0]   trial;
  logic                  trial_ge;
  logic                  out_load;

  // Bits above VALUE_BITS are dropped, and a zero value counts as one.
  assign v_ext = {{VALUE_BITS{1'b0}}, in_word.value};
  assign v_in  = (v_ext[VALUE_BITS-1:0] == '0) ? VALUE_BITS'(1) : v_ext[VALUE_BITS-1:0];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (seen >= LEN_W'(MAX_LEN));

  assign slot_sum = SLOT_W'(head) + SLOT_W'(length);
  assign slot     = (slot_sum >= SLOT_W'(MAX_LEN)) ?
                    HEAD_W'(slot_sum - SLOT_W'(MAX_LEN)) : HEAD_W'(slot_sum);
  assign head_inc = (head == HEAD_W'(MAX_LEN - 1)) ? '0 : head + HEAD_W'(1);

  assign shrink    = (length != '0) && (product >= PROD_W'(limit));
  assign count_sum = {1'b0, count} + (COUNT_W+1)'(length);
  assign count_sat = (count_sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : count_sum[COUNT_W-1:0];

  assign trial    = {div_rem, div_q[PROD_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});

  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // Ring memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (accept && !full) begin
      mem[slot] <= v_in;
    end
    rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (full) begin
            state_next = in_word.is_last ? S_DONE : S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL:   state_next = S_CHECK;
      S_CHECK: begin
        if (shrink) begin
          state_next = S_READ;
        end else begin
          state_next = last_flag ? S_DONE : S_IDLE;
        end
      end
      S_READ:  state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == DCNT_W'(PROD_W - 1)) begin
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= '0;
      product   <= PROD_W'(1);
      head      <= '0;
      length    <= '0;
      count     <= '0;
      seen      <= '0;
      ovf       <= 1'b0;
      last_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_flag <= in_word.is_last;
            if (full) begin
              ovf <= 1'b1;
            end else begin
              v_reg  <= v_in;
              length <= length + LEN_W'(1);
              seen   <= seen + LEN_W'(1);
            end
          end
        end
        S_MUL: begin
          // The product is below the limit, or one, before the new value comes in.
          product <= PROD_W'(product[LIMIT_W-1:0]) * PROD_W'(v_reg);
        end
        S_CHECK: begin
          if (!shrink) begin
            if (length == '0) begin
              product <= PROD_W'(1);
            end
            count <= count_sat;
          end
        end
        S_READ: begin
          divisor <= (rd_data == '0) ? VALUE_BITS'(1) : rd_data;
          div_q   <= product;
          div_rem <= '0;
          div_cnt <= '0;
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle; the quotient is exact.
          div_q   <= {div_q[PROD_W-2:0], trial_ge};
          div_rem <= trial_ge ? VALUE_BITS'(trial - {1'b0, divisor}) : trial[VALUE_BITS-1:0];
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(PROD_W - 1)) begin
            product <= {div_q[PROD_W-2:0], trial_ge};
            head    <= head_inc;
            length  <= length - LEN_W'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_word.subarray_count  <= ovf ? COUNT_MAX : count;
            out_word.overflow        <= ovf;
            product                  <= PROD_W'(1);
            head                     <= '0;
            length                   <= '0;
            count                    <= '0;
            seen                     <= '0;
            ovf                      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
